/* hw/rtl/mtg_pkg.sv */
// Shared types, constants and codes for the MT19937 generator.
package mtg_pkg;

    localparam int unsigned MT_WORDS  = 624;
    localparam int unsigned MT_SHIFT  = 397;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned IDX_W     = $clog2(MT_WORDS);

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(MT_WORDS - 1);
    localparam logic [WORD_W-1:0] MT_MATRIX   = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] MT_TEMPER_B = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] MT_TEMPER_C = 32'hEFC6_0000;
    localparam logic [WORD_W-1:0] MT_SEED_MUL = 32'h6C07_8965;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef logic [WORD_W-1:0] mtg_word_t;
    typedef logic [IDX_W-1:0]  mtg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_DISCARD,
        ST_HOLD
    } mtg_state_t;

    typedef struct packed {
        logic     load;
        logic     advance;
        mtg_idx_t step_num;
    } mtg_seed_ctrl_t;

endpackage

/* hw/rtl/mtg_if.sv */
// Valid/ready channel interfaces for the command and result sides.
interface mtg_cmd_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] seed_value;

    modport source (output valid, output opcode, output seed_value, input ready);
    modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface mtg_rnd_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

/* hw/rtl/mtg_cell.sv */
// One cell of the state ring: holds a word and takes its neighbor's word on shift.
module mtg_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  mtg_pkg::mtg_word_t word_in,
    output mtg_pkg::mtg_word_t word_out
);
    import mtg_pkg::*;

    mtg_word_t word_reg;
    mtg_word_t word_next;

    always_comb
    begin
        word_next = shift ? word_in : word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

/* hw/rtl/mtg_seeder.sv */
// Seed recurrence unit: produces one initialization word per advance.
module mtg_seeder (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mtg_pkg::mtg_seed_ctrl_t ctrl,
    input  mtg_pkg::mtg_word_t      seed,
    output mtg_pkg::mtg_word_t      word
);
    import mtg_pkg::*;

    mtg_word_t prev_reg;
    mtg_word_t prev_next;
    mtg_word_t mixed;
    mtg_word_t product;

    always_comb
    begin
        mixed     = prev_reg ^ (prev_reg >> 30);
        product   = MT_SEED_MUL * mixed;
        priority if (ctrl.load)
        begin
            prev_next = seed;
        end
        else if (ctrl.advance)
        begin
            prev_next = product + WORD_W'(ctrl.step_num);
        end
        else
        begin
            prev_next = prev_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

    assign word = prev_reg;

endmodule

/* hw/rtl/mt19937_generator_unit.sv */
// Top level of the MT19937 generator: ring of state cells, sequencer and result register.
//
// The 624-word state lives in a ring of 624 cells that rotates one word per
// shift, so the current word always sits in the first cell and its twist
// partners sit in cells 1 and 397; reset clears every cell to zero. A draw
// transaction takes the tempered word of the first cell into a register for the
// result channel, or parks it as below, and shifts the ring once. A seed
// transaction shifts the seed recurrence into every cell (one 32x32 multiply
// per cycle), then re-twists the whole ring unread; it yields no result.
// One finished result may wait in the output register while the next draw is
// taken; that draw is parked and the command side stalls until the result
// side takes the first one.
module mt19937_generator_unit (
    input  logic          clk,
    input  logic          rst_n,
    mtg_cmd_if.sink       cmd,
    mtg_rnd_if.source     rnd
);
    import mtg_pkg::*;

    mtg_state_t     state_reg;
    mtg_state_t     state_next;
    mtg_idx_t       count_reg;
    mtg_idx_t       count_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    mtg_word_t      out_word_reg;
    mtg_word_t      out_word_next;
    mtg_word_t      pend_word_reg;
    mtg_word_t      pend_word_next;

    logic           cmd_acc;
    logic           out_free;
    logic           count_last;
    logic           ring_shift;
    logic           feed_seed;
    logic           load_out_now;
    logic           load_pend;
    logic           load_out_pend;
    logic           count_clear;
    logic           count_inc;
    mtg_seed_ctrl_t seed_ctrl;
    mtg_word_t      seed_word;
    mtg_word_t      twist_word;
    mtg_word_t      temper_word;
    mtg_word_t      chain_in;
    mtg_word_t      mix;
    mtg_word_t      cell_word [MT_WORDS];

    function automatic mtg_word_t mtg_temper(input mtg_word_t w);
        mtg_word_t t;
        t = w;
        t = t ^ (t >> 11);
        t = t ^ ((t << 7) & MT_TEMPER_B);
        t = t ^ ((t << 15) & MT_TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_acc    = cmd.valid && cmd.ready;
    assign out_free   = !out_valid_reg || rnd.ready;
    assign count_last = (count_reg == LAST_IDX);

    always_comb
    begin
        mix = {1'b0, cell_word[0][31], cell_word[1][30:1]};
        if (cell_word[1][0])
        begin
            mix = mix ^ MT_MATRIX;
        end
        twist_word  = mix ^ cell_word[MT_SHIFT];
        temper_word = mtg_temper(cell_word[0]);
        chain_in    = feed_seed ? seed_word : twist_word;
    end

    genvar g;
    generate
        for (g = 0; g < MT_WORDS; g++)
        begin : g_ring
            if (g == MT_WORDS - 1)
            begin : g_tail
                mtg_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (ring_shift),
                    .word_in  (chain_in),
                    .word_out (cell_word[g])
                );
            end
            else
            begin : g_body
                mtg_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift    (ring_shift),
                    .word_in  (cell_word[g+1]),
                    .word_out (cell_word[g])
                );
            end
        end
    endgenerate

    mtg_seeder u_seeder (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (seed_ctrl),
        .seed  (cmd.seed_value),
        .word  (seed_word)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (cmd.opcode == OP_SEED)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (!out_free)
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_FILL:
            begin
                if (count_last)
                begin
                    state_next = ST_DISCARD;
                end
            end
            ST_DISCARD:
            begin
                if (count_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ring_shift         = 1'b0;
        feed_seed          = 1'b0;
        load_out_now       = 1'b0;
        load_pend          = 1'b0;
        load_out_pend      = 1'b0;
        count_clear        = 1'b0;
        count_inc          = 1'b0;
        seed_ctrl.load     = 1'b0;
        seed_ctrl.advance  = 1'b0;
        seed_ctrl.step_num = count_reg + 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (cmd.opcode == OP_SEED)
                    begin
                        seed_ctrl.load = 1'b1;
                        count_clear    = 1'b1;
                    end
                    else
                    begin
                        ring_shift   = 1'b1;
                        load_out_now = out_free;
                        load_pend    = !out_free;
                    end
                end
            end
            ST_FILL:
            begin
                ring_shift        = 1'b1;
                feed_seed         = 1'b1;
                seed_ctrl.advance = 1'b1;
                count_clear       = count_last;
                count_inc         = !count_last;
            end
            ST_DISCARD:
            begin
                ring_shift  = 1'b1;
                count_clear = count_last;
                count_inc   = !count_last;
            end
            ST_HOLD:
            begin
                load_out_pend = out_free;
            end
            default:
            begin
                ring_shift = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (count_clear)
        begin
            count_next = '0;
        end
        else if (count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end

        priority if (load_out_now)
        begin
            out_valid_next = 1'b1;
            out_word_next  = temper_word;
        end
        else if (load_out_pend)
        begin
            out_valid_next = 1'b1;
            out_word_next  = pend_word_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg && !rnd.ready;
            out_word_next  = out_word_reg;
        end

        pend_word_next = load_pend ? temper_word : pend_word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        pend_word_reg <= pend_word_next;
    end

    assign rnd.valid       = out_valid_reg;
    assign rnd.random_word = out_word_reg;

    a_draw_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_acc && cmd.opcode == OP_DRAW && out_free) |=> out_valid_reg)
        else $error("draw taken with free output did not produce a result");

    a_fill_to_discard: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && count_last) |=> (state_reg == ST_DISCARD))
        else $error("fill phase did not hand over to discard phase");

    a_no_result_while_seeding: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_HOLD))
        else $error("result appeared during seeding");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_IDX)
        else $error("phase counter beyond last ring position");

    a_hold_keeps_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> !ring_shift)
        else $error("ring shifted while a draw result was parked");

endmodule
